// File: rtl/lpf_pkg.sv
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types for the largest prime factor block: controller states and the
// command/status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package lpf_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_TRY,
    ST_DIV,
    ST_FINISH
  } lpf_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;         // capture a new number, best = 0, divisor = 3
    logic strip;        // shift out one factor of two, best = 2
    logic div_start;    // start a serial divide of n by d
    logic take_factor;  // divisor divided: best = d, n = quotient
    logic next_div;     // advance to next odd divisor
    logic out_load;     // write final answer into the output register
  } lpf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic n_lt2;        // working value below two
    logic n_even;       // working value has a factor of two
    logic div_busy;     // serial divider still running
    logic d_gt_q;       // divisor exceeds quotient (square test fails)
    logic rem_zero;     // divisor divides the working value
  } lpf_stat_t;

endpackage

// File: rtl/lpf_div.sv
// ----------------------------------------------------------------------------
// lpf_div
// Restoring serial divider: one quotient bit per cycle. Quotient and
// remainder hold after completion until the next start.
// ----------------------------------------------------------------------------
module lpf_div #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  // One restoring step
  always_comb begin
    shifted = {rem, quo[WIDTH-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = (shifted >= {1'b0, divisor});
  end

  // Control: busy flag and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(WIDTH);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo <= {quo[WIDTH-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("divider not busy after start");
  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cnt == '0))
    else $error("divider idle with steps left");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start)
    else $error("divider restarted while busy");
`endif

endmodule

// File: rtl/lpf_dp.sv
// ----------------------------------------------------------------------------
// lpf_dp
// Datapath: working value, odd trial divisor, best factor so far, the serial
// divider, and the output register.
// ----------------------------------------------------------------------------
module lpf_dp #(
  parameter int WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  lpf_pkg::lpf_cmd_t cmd,
  input  logic [WIDTH-1:0]  number,
  output lpf_pkg::lpf_stat_t stat,
  output logic [WIDTH-1:0]  largest_factor
);

  import lpf_pkg::*;

  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] d;
  logic [WIDTH-1:0] best;
  logic [WIDTH-1:0] quotient;
  logic [WIDTH-1:0] remainder;
  logic             div_busy;

  lpf_div #(.WIDTH(WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (n),
    .divisor  (d),
    .busy     (div_busy),
    .quotient (quotient),
    .remainder(remainder)
  );

  // Working value and best factor
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n    <= number;
      best <= '0;
    end else if (cmd.strip) begin
      n    <= n >> 1;
      best <= WIDTH'(2);
    end else if (cmd.take_factor) begin
      n    <= quotient;
      best <= d;
    end
  end

  // Odd trial divisor
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      d <= WIDTH'(3);
    end else if (cmd.next_div) begin
      d <= d + WIDTH'(2);
    end
  end

  // Output register: leftover quotient above two wins
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      largest_factor <= (n > WIDTH'(2)) ? n : best;
    end
  end

  // Status
  always_comb begin
    stat.n_lt2    = ((n >> 1) == '0);
    stat.n_even   = ~n[0];
    stat.div_busy = div_busy;
    stat.d_gt_q   = (d > quotient);
    stat.rem_zero = (remainder == '0);
  end

`ifndef SYNTHESIS
  a_d_odd: assert property (@(posedge clk) disable iff (rst)
    d[0] == 1'b1)
    else $error("trial divisor is even");
  a_strip_even: assert property (@(posedge clk) disable iff (rst)
    cmd.strip |-> (n[0] == 1'b0))
    else $error("strip on odd value");
  a_take_exact: assert property (@(posedge clk) disable iff (rst)
    cmd.take_factor |-> (remainder == '0 && !div_busy))
    else $error("factor taken without exact divide");
`endif

endmodule

// File: rtl/lpf_ctrl.sv
// ----------------------------------------------------------------------------
// lpf_ctrl
// Controller: sequences strip-twos, trial divides and the final write, and
// owns the request handshakes on both channels.
// ----------------------------------------------------------------------------
module lpf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  lpf_pkg::lpf_stat_t stat,
  output lpf_pkg::lpf_cmd_t  cmd
);

  import lpf_pkg::*;

  lpf_state_t state;
  lpf_state_t state_next;
  logic       inner;       // working value just changed by a divide-out
  logic       inner_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      inner <= 1'b0;
    end else begin
      state <= state_next;
      inner <= inner_next;
    end
  end

  // Output valid: set on load, cleared when the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    inner_next = inner;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (stat.n_lt2) begin
          state_next = ST_FINISH;
        end else if (stat.n_even) begin
          cmd.strip = 1'b1;
        end else begin
          inner_next = 1'b0;
          state_next = ST_TRY;
        end
      end
      ST_TRY: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          if (!inner && stat.d_gt_q) begin
            state_next = ST_FINISH;
          end else if (stat.rem_zero) begin
            cmd.take_factor = 1'b1;
            inner_next      = 1'b1;
            state_next      = ST_TRY;
          end else begin
            cmd.next_div = 1'b1;
            inner_next   = 1'b0;
            state_next   = ST_TRY;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_accept_strip: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_STRIP))
    else $error("accepted request did not start stripping");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwrote a pending request");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("pending result dropped");
`endif

endmodule

// File: rtl/largest_prime_factor_top.sv
// ----------------------------------------------------------------------------
// largest_prime_factor_top
// Largest prime factor by trial division: strips factors of two, then divides
// out odd divisors 3, 5, 7, ... while divisor squared <= remaining quotient.
//
//   channel  | signals                         | direction
//   ---------+---------------------------------+----------
//   input    | in_valid, in_stall, number      | in
//   output   | out_valid, out_stall,           | out
//            | largest_factor                  |
//
// One number at a time: a load, one strip step per factor of two, then
// trial divides, each a start step plus a run of the bit-serial divider.
// A WIDTH=32 prime needs about 32768 divides.
// Reset is synchronous, active high; no clearing pass.
// The next request is taken once the previous answer sits in the output
// register; a stalled output holds the block in its final state.
// ----------------------------------------------------------------------------
module largest_prime_factor_top #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] number,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] largest_factor
);

  import lpf_pkg::*;

  lpf_cmd_t  cmd;
  lpf_stat_t stat;

  lpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpf_dp #(.WIDTH(WIDTH)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .number        (number),
    .stat          (stat),
    .largest_factor(largest_factor)
  );

endmodule

// File: verif/largest_prime_factor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// largest_prime_factor_checker
// Watches both channels of the largest prime factor block. Every accepted
// request is factored here by trial division and the answer is queued. Every
// accepted result is compared with the oldest queued answer.
// ----------------------------------------------------------------------------
module largest_prime_factor_checker #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [WIDTH-1:0] number,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [WIDTH-1:0] largest_factor,
  output int               errors,
  output int               pending
);

  logic [WIDTH-1:0] factor_q[$];

  // Trial division: strip twos, then odd divisors while d*d <= quotient
  function automatic logic [WIDTH-1:0] largest_prime(input logic [WIDTH-1:0] value);
    logic [WIDTH-1:0] quo;
    logic [WIDTH-1:0] div;
    logic [WIDTH-1:0] best;
    if (value < 2) return '0;
    quo  = value;
    best = '0;
    while (quo[0] == 1'b0) begin
      best = WIDTH'(2);
      quo  = quo >> 1;
    end
    div = WIDTH'(3);
    while (div <= quo / div) begin
      while (quo % div == 0) begin
        best = div;
        quo  = quo / div;
      end
      div = div + WIDTH'(2);
    end
    if (quo > 2) best = quo;
    return best;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    logic [WIDTH-1:0] want;
    if (rst) begin
      factor_q.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) factor_q.push_back(largest_prime(number));
      if (out_valid && !out_stall) begin
        if (factor_q.size() == 0) begin
          $error("largest_factor: expected none, actual %0d", largest_factor);
          errors++;
        end else begin
          want = factor_q.pop_front();
          if (largest_factor !== want) begin
            $error("largest_factor: expected %0d, actual %0d", want, largest_factor);
            errors++;
          end
        end
      end
    end
    pending = factor_q.size();
  end

endmodule

// File: verif/tb_largest_prime_factor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_largest_prime_factor_top
// Drives requests into the largest prime factor block: directed corner values
// first, then random numbers, mostly a modest core times small primes
// so that every bit is exercised while runtimes stay short. Random stalls on
// the result side, one long hold-off, and a quiet tail end the run.
// ----------------------------------------------------------------------------
module tb_largest_prime_factor_top;

  localparam int WIDTH        = 32;
  localparam int RAND_COUNT   = 80;
  localparam int QUIET_TAIL   = 15;
  localparam int HOLD_CYCLES  = 20000;
  localparam int HOLD_AFTER   = 30;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 8000000;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [WIDTH-1:0] number    = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [WIDTH-1:0] largest_factor;

  int errors;
  int pending;
  int cycles     = 0;
  int sent_total = 0;
  bit quiet      = 1'b0;
  bit hold_done  = 1'b0;

  always #6 clk = ~clk;

  largest_prime_factor_top #(.WIDTH(WIDTH)) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .number         (number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .largest_factor (largest_factor)
  );

  largest_prime_factor_checker #(.WIDTH(WIDTH)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .number         (number),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .largest_factor (largest_factor),
    .errors         (errors),
    .pending        (pending)
  );

  // Offer one request and hold it until the block takes it
  task automatic send_number(input logic [WIDTH-1:0] value);
    number   <= value;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_total++;
  endtask

  // Optional sender gap after an accepted request
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Random number: small core keeps the trial loop short
  function automatic logic [WIDTH-1:0] random_number();
    logic [63:0] acc;
    logic [63:0] prime;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return WIDTH'($urandom_range(0, 2000));
    if (mode == 1) return WIDTH'(64'($urandom_range(1, 255)) << $urandom_range(0, 24));
    acc = 64'($urandom_range(2, 131072));
    while ($urandom_range(0, 15) != 0) begin
      case ($urandom_range(0, 5))
        0:       prime = 2;
        1:       prime = 3;
        2:       prime = 5;
        3:       prime = 7;
        4:       prime = 11;
        default: prime = 13;
      endcase
      if (acc * prime > 64'hFFFF_FFFF) break;
      acc = acc * prime;
    end
    return acc[WIDTH-1:0];
  endfunction

  // Request stimulus
  initial begin
    logic [WIDTH-1:0] directed[$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd9, 32'd15,
                 32'd25, 32'd49, 32'd60491, 32'd65521, 32'd65537, 32'd131071,
                 32'h8000_0000, 32'hC000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'd3486784401, 32'd1977326743, 32'd4293984256};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      send_number(directed[i]);
      sender_gap();
    end
    for (int i = 0; i < RAND_COUNT; i++) begin
      if (i >= RAND_COUNT - QUIET_TAIL) quiet = 1'b1;
      send_number(random_number());
      sender_gap();
    end
    in_valid <= 1'b0;
    // let the checker log the last request, drain, then settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Result-side stalls, with one long hold-off to back up the input
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!hold_done && sent_total >= HOLD_AFTER) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

// File: largest_prime_factor_top.f
rtl/lpf_pkg.sv
rtl/lpf_div.sv
rtl/lpf_dp.sv
rtl/lpf_ctrl.sv
rtl/largest_prime_factor_top.sv
verif/largest_prime_factor_checker.sv
verif/tb_largest_prime_factor_top.sv
